>>> hdl/otdc_pkg.sv
package otdc_pkg;

  localparam int unsigned KeyW   = 3;
  localparam int unsigned EdgeW  = 1;
  localparam int unsigned OppW   = 5;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SpeedW = 11;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned DurW   = 9;

  typedef enum logic [KeyW-1:0] {
    KEY_NONE     = 3'd0,
    KEY_ARM      = 3'd1,
    KEY_FIGHT    = 3'd2,
    KEY_STOP     = 3'd3,
    KEY_EDGE_OFF = 3'd4
  } otdc_key_e;

  localparam int unsigned OppSl = 0;
  localparam int unsigned OppFl = 1;
  localparam int unsigned OppC  = 2;
  localparam int unsigned OppFr = 3;
  localparam int unsigned OppSr = 4;

  localparam logic [CfgW-1:0] SearchTurnRst = 16'd500;

  localparam logic [DurW-1:0] ReactShortMs = 9'd200;
  localparam logic [DurW-1:0] ReactLongMs  = 9'd300;

  typedef logic signed [SpeedW-1:0] otdc_speed_t;

  localparam otdc_speed_t SpdZero     = 11'sd0;
  localparam otdc_speed_t SpdFull     = 11'sd1000;
  localparam otdc_speed_t SpdCenter   = 11'sd800;
  localparam otdc_speed_t SpdVeerHi   = 11'sd600;
  localparam otdc_speed_t SpdVeerLo   = 11'sd300;
  localparam otdc_speed_t SpdPivot    = 11'sd500;
  localparam otdc_speed_t SpdSearch   = 11'sd400;
  localparam otdc_speed_t SpdSearchNg = -11'sd400;
  localparam otdc_speed_t SpdRevBoth  = -11'sd500;
  localparam otdc_speed_t SpdRevHard  = -11'sd700;
  localparam otdc_speed_t SpdRevSoft  = -11'sd250;

  typedef struct packed {
    logic [KeyW-1:0]  remote_key;
    logic             edge_right;
    logic             edge_left;
    logic [OppW-1:0]  opponent_seen;
    logic [TimeW-1:0] now_ms;
  } otdc_req_t;

  typedef struct packed {
    otdc_speed_t motor_right;
    otdc_speed_t motor_left;
    logic        drive_issued;
    logic        flag_raised;
    logic        arm_indicator;
  } otdc_rsp_t;

endpackage

>>> hdl/otdc_if.sv
interface otdc_req_if;
  logic                            valid;
  logic                            ready;
  logic [otdc_pkg::KeyW-1:0]       remote_key;
  logic                            edge_right;
  logic                            edge_left;
  logic [otdc_pkg::OppW-1:0]       opponent_seen;
  logic [otdc_pkg::TimeW-1:0]      now_ms;

  modport source (output valid, remote_key, edge_right, edge_left, opponent_seen, now_ms,
                  input ready);
  modport sink   (input valid, remote_key, edge_right, edge_left, opponent_seen, now_ms,
                  output ready);
endinterface

interface otdc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [otdc_pkg::SpeedW-1:0] motor_right;
  logic signed [otdc_pkg::SpeedW-1:0] motor_left;
  logic                             drive_issued;
  logic                             flag_raised;
  logic                             arm_indicator;

  modport source (output valid, motor_right, motor_left, drive_issued, flag_raised,
                  arm_indicator, input ready);
  modport sink   (input valid, motor_right, motor_left, drive_issued, flag_raised,
                  arm_indicator, output ready);
endinterface

>>> hdl/opponent_tracking_drive_controller_unit.sv
// Drive controller for an opponent-tracking robot. Every accepted request is one
// control pass and yields exactly one response. Throughput is one request per
// clock while not stalled. The pass logic is a key filter, an edge-reaction
// timer, the opponent priority decode and a search-turn timer, each timer one
// 32-bit subtract and compare. Requests pass the input register, the pass logic
// and the response register; the response register may hold a finished response
// while the input register already holds the next request. A stalled response
// stalls the pass. search_turn_q is written through cfg_we_i/cfg_wdata_i, reset 500 ms.
module opponent_tracking_drive_controller_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [otdc_pkg::CfgW-1:0] cfg_wdata_i,
  otdc_req_if.sink                  req_i,
  otdc_rsp_if.source                rsp_o
);
  import otdc_pkg::*;

  logic      s1_valid_q;
  otdc_req_t s1_req_q;
  logic      out_valid_q;
  otdc_rsp_t out_rsp_q;
  otdc_rsp_t pass_rsp;
  logic      advance;
  logic      accept;
  logic      step;

  assign advance     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;
  assign step        = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q.remote_key    <= req_i.remote_key;
      s1_req_q.edge_right    <= req_i.edge_right;
      s1_req_q.edge_left     <= req_i.edge_left;
      s1_req_q.opponent_seen <= req_i.opponent_seen;
      s1_req_q.now_ms        <= req_i.now_ms;
    end
  end

  otdc_pass u_pass (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .req_i       (s1_req_q),
    .rsp_o       (pass_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rsp_q <= pass_rsp;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.motor_right   = out_rsp_q.motor_right;
  assign rsp_o.motor_left    = out_rsp_q.motor_left;
  assign rsp_o.drive_issued  = out_rsp_q.drive_issued;
  assign rsp_o.flag_raised   = out_rsp_q.flag_raised;
  assign rsp_o.arm_indicator = out_rsp_q.arm_indicator;

endmodule

>>> hdl/otdc_pass.sv
module otdc_pass (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [otdc_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      step_i,
  input  otdc_pkg::otdc_req_t       req_i,
  output otdc_pkg::otdc_rsp_t       rsp_o
);
  import otdc_pkg::*;

  logic [CfgW-1:0]  search_turn_q;
  otdc_key_e        rem_key_q, rem_key_d;
  logic             flag_q, flag_d;
  logic             edge_on_q, edge_on_d;
  logic             reacting_q, reacting_d;
  logic [TimeW-1:0] react_start_q, react_start_d;
  logic             turning_q, turning_d;
  logic [TimeW-1:0] turn_start_q, turn_start_d;
  logic [OppW-1:0]  last_seen_q, last_seen_d;
  otdc_speed_t      right_q, right_d;
  otdc_speed_t      left_q, left_d;

  otdc_key_e        raw_key;
  otdc_key_e        key;
  logic [DurW-1:0]  react_dur;
  logic [TimeW-1:0] react_elapsed;
  logic [TimeW-1:0] turn_elapsed;
  logic [OppW-1:0]  opp;
  logic             er, el;

  always_comb begin
    opp           = req_i.opponent_seen;
    er            = req_i.edge_right;
    el            = req_i.edge_left;
    raw_key       = (req_i.remote_key > KEY_EDGE_OFF) ? KEY_NONE
                                                      : otdc_key_e'(req_i.remote_key);
    if (rem_key_q == KEY_FIGHT && raw_key != KEY_STOP) begin
      key = KEY_FIGHT;
    end else if (rem_key_q == KEY_STOP) begin
      key = KEY_STOP;
    end else begin
      key = raw_key;
    end

    rem_key_d     = key;
    flag_d        = flag_q;
    edge_on_d     = edge_on_q;
    reacting_d    = reacting_q;
    react_start_d = react_start_q;
    turning_d     = turning_q;
    turn_start_d  = turn_start_q;
    last_seen_d   = last_seen_q;
    right_d       = right_q;
    left_d        = left_q;
    react_dur     = ReactShortMs;
    react_elapsed = '0;
    turn_elapsed  = '0;
    rsp_o         = '0;

    unique case (key)
      KEY_NONE: begin
      end
      KEY_ARM: begin
        rsp_o.arm_indicator = 1'b1;
      end
      KEY_FIGHT: begin
        flag_d             = 1'b1;
        rsp_o.drive_issued = 1'b1;
        // edge reaction
        if (edge_on_q) begin
          if (!reacting_q && (er || el)) begin
            reacting_d    = 1'b1;
            react_start_d = req_i.now_ms;
          end
          if (reacting_d) begin
            if (er && el) begin
              react_dur = ReactShortMs;
              right_d   = SpdRevBoth;
              left_d    = SpdRevBoth;
            end else if (er) begin
              react_dur = ReactLongMs;
              right_d   = SpdRevHard;
              left_d    = SpdRevSoft;
            end else if (el) begin
              react_dur = ReactLongMs;
              right_d   = SpdRevSoft;
              left_d    = SpdRevBoth;
            end else begin
              react_dur = ReactShortMs;
              right_d   = SpdSearchNg;
              left_d    = SpdSearchNg;
            end
            react_elapsed = req_i.now_ms - react_start_d;
            if (react_elapsed >= TimeW'(react_dur)) begin
              reacting_d = 1'b0;
            end
          end
        end
        // opponent tracking and search
        if (reacting_d) begin
          turning_d = 1'b0;
        end else if (opp != '0) begin
          turning_d   = 1'b0;
          last_seen_d = opp;
          if (opp[OppFl] && opp[OppC]) begin
            right_d = SpdFull;
            left_d  = SpdFull;
          end else if (opp[OppC] && opp[OppFr]) begin
            right_d = SpdFull;
            left_d  = SpdFull;
          end else if (opp[OppSl] && opp[OppFl]) begin
            right_d = SpdVeerLo;
            left_d  = SpdVeerHi;
          end else if (opp[OppFr] && opp[OppSr]) begin
            right_d = SpdVeerHi;
            left_d  = SpdVeerLo;
          end else if (opp[OppSl]) begin
            right_d = SpdZero;
            left_d  = SpdPivot;
          end else if (opp[OppSr]) begin
            right_d = SpdPivot;
            left_d  = SpdZero;
          end else if (opp[OppC]) begin
            right_d = SpdCenter;
            left_d  = SpdCenter;
          end
        end else begin
          turning_d = 1'b1;
          if (!turning_q) begin
            turn_start_d = req_i.now_ms;
          end
          turn_elapsed = req_i.now_ms - turn_start_d;
          if (turn_elapsed >= TimeW'(search_turn_q)) begin
            turning_d   = 1'b0;
            last_seen_d = '0;
            right_d     = SpdSearch;
            left_d      = SpdSearch;
          end else if (last_seen_q[OppSl] || last_seen_q[OppFl]) begin
            right_d = SpdSearch;
            left_d  = SpdZero;
          end else if (last_seen_q[OppFr] || last_seen_q[OppSr]) begin
            right_d = SpdZero;
            left_d  = SpdSearch;
          end else begin
            right_d = SpdSearch;
            left_d  = SpdSearchNg;
          end
        end
        rsp_o.motor_right = right_d;
        rsp_o.motor_left  = left_d;
      end
      KEY_STOP: begin
        rsp_o.drive_issued = 1'b1;
        flag_d             = 1'b0;
      end
      KEY_EDGE_OFF: begin
        edge_on_d = 1'b0;
      end
      default: begin
      end
    endcase

    rsp_o.flag_raised = flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_turn_q <= SearchTurnRst;
    end else if (cfg_we_i) begin
      search_turn_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_key_q     <= KEY_NONE;
      flag_q        <= 1'b0;
      edge_on_q     <= 1'b1;
      reacting_q    <= 1'b0;
      react_start_q <= '0;
      turning_q     <= 1'b0;
      turn_start_q  <= '0;
      last_seen_q   <= '0;
      right_q       <= SpdZero;
      left_q        <= SpdZero;
    end else if (step_i) begin
      rem_key_q     <= rem_key_d;
      flag_q        <= flag_d;
      edge_on_q     <= edge_on_d;
      reacting_q    <= reacting_d;
      react_start_q <= react_start_d;
      turning_q     <= turning_d;
      turn_start_q  <= turn_start_d;
      last_seen_q   <= last_seen_d;
      right_q       <= right_d;
      left_q        <= left_d;
    end
  end

endmodule

>>> hdl/otdc_checker.sv
module otdc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               rsp_valid_i,
  input logic                               rsp_ready_i,
  input logic signed [otdc_pkg::SpeedW-1:0] motor_right_i,
  input logic signed [otdc_pkg::SpeedW-1:0] motor_left_i,
  input logic                               drive_issued_i,
  input logic                               flag_raised_i,
  input logic                               arm_indicator_i
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(motor_right_i)
      && $stable(motor_left_i) && $stable(drive_issued_i)
      && $stable(flag_raised_i) && $stable(arm_indicator_i))
    else $error("response changed while stalled");

  a_idle_motors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !drive_issued_i |-> motor_right_i == '0 && motor_left_i == '0)
    else $error("motor command without drive");

  a_arm_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && arm_indicator_i |-> !drive_issued_i && !flag_raised_i)
    else $error("arm pass drove or raised flag");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && drive_issued_i && !flag_raised_i
      |-> motor_right_i == '0 && motor_left_i == '0)
    else $error("stop pass with nonzero motors");

endmodule

bind opponent_tracking_drive_controller_unit otdc_checker u_otdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .motor_right_i   (rsp_o.motor_right),
  .motor_left_i    (rsp_o.motor_left),
  .drive_issued_i  (rsp_o.drive_issued),
  .flag_raised_i   (rsp_o.flag_raised),
  .arm_indicator_i (rsp_o.arm_indicator)
);
